>>> rtl/best_fit_block_allocator_macros.svh
// assertion macros used by the checker file
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, reset disables the check
`define BFBA_AST_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables the check
`define BFBA_AST_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bfba_pkg.sv
package bfba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;

	localparam int OWNER_W = 8;
	localparam int SIZE_W  = 5;
	localparam int STAT_W  = 2;
	localparam int START_W = 4;
	localparam int LEN_W   = 5;
	localparam int CNT_W   = 5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic start;    // latch request, clear scan state
		logic scan;     // walk the block map
		logic clr_cnt;  // rewind the shared counter
		logic fill;     // write owner into the chosen run
		logic load;     // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic fit;
		logic fill_done;
	} sts_t;

endpackage

>>> rtl/bfba_dp.sv
module bfba_dp #(
	parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bfba_pkg::cmd_t                   cmd,
	output bfba_pkg::sts_t                   sts,
	input  logic                             in_op,
	input  logic [bfba_pkg::OWNER_W-1:0]     in_owner,
	input  logic [bfba_pkg::SIZE_W-1:0]      in_size,
	output logic [bfba_pkg::STAT_W-1:0]      res_status,
	output logic [bfba_pkg::START_W-1:0]     res_start,
	output logic [bfba_pkg::LEN_W-1:0]       res_len,
	output logic [bfba_pkg::CNT_W-1:0]       res_freed
);

	localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int LW = ((CW > bfba_pkg::SIZE_W) ? CW : bfba_pkg::SIZE_W) + 1;

	logic [bfba_pkg::OWNER_W-1:0] mem_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0]        valid_q;

	logic                         op_q;
	logic [bfba_pkg::OWNER_W-1:0] owner_q;
	logic [bfba_pkg::SIZE_W-1:0]  want_q;
	logic [CW-1:0]                cnt_q;

	logic                         pv_s1;
	logic [IW-1:0]                idx_s1;
	logic [bfba_pkg::OWNER_W-1:0] rdata_s1;
	logic                         vld_s1;

	logic [CW-1:0] run_len_q;
	logic [IW-1:0] run_start_q;
	logic [CW-1:0] best_len_q;
	logic [IW-1:0] best_start_q;
	logic          found_q;
	logic [CW-1:0] count_q;

	logic          issue;
	logic          is_free;
	logic          closes;
	logic [CW-1:0] cand_len;
	logic [IW-1:0] cand_start;
	logic          take;
	logic          match;
	logic [IW-1:0] waddr;

	assign issue = cmd.scan && (cnt_q != CW'(NUM_BLOCKS));
	assign is_free = !vld_s1;
	assign closes = !is_free || (idx_s1 == IW'(NUM_BLOCKS - 1));
	assign cand_len = is_free ? run_len_q + CW'(1) : run_len_q;
	assign cand_start = (is_free && run_len_q == '0) ? idx_s1 : run_start_q;
	assign take = closes && (want_q != '0) && (owner_q != '0)
		&& (LW'(cand_len) >= LW'(want_q))
		&& (!found_q || cand_len < best_len_q);
	assign match = vld_s1 && (rdata_s1 == owner_q) && (owner_q != '0);
	assign waddr = best_start_q + cnt_q[IW-1:0];

	assign sts.scan_done = (cnt_q == CW'(NUM_BLOCKS));
	assign sts.fit = (op_q == bfba_pkg::OP_ALLOC) && found_q;
	assign sts.fill_done = ((LW'(cnt_q) + LW'(1)) == LW'(want_q));

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= in_op;
			owner_q <= in_owner;
			want_q <= in_size;
		end
	end

	// shared scan / fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start || cmd.clr_cnt) begin
			cnt_q <= '0;
		end else if (issue || cmd.fill) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// map read, one entry per cycle
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem_q[cnt_q[IW-1:0]];
			vld_s1 <= valid_q[cnt_q[IW-1:0]];
			idx_s1 <= cnt_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= issue;
		end
	end

	// map write during fill
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			mem_q[waddr] <= owner_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.fill) begin
			valid_q[waddr] <= 1'b1;
		end else if (pv_s1 && op_q == bfba_pkg::OP_FREE && match) begin
			valid_q[idx_s1] <= 1'b0;
		end
	end

	// run tracking and free counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
			found_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.start) begin
			run_len_q <= '0;
			found_q <= 1'b0;
			count_q <= '0;
		end else if (pv_s1) begin
			if (op_q == bfba_pkg::OP_ALLOC) begin
				if (take) begin
					found_q <= 1'b1;
				end
				if (closes) begin
					run_len_q <= '0;
				end else begin
					run_len_q <= cand_len;
				end
			end else if (match) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pv_s1 && op_q == bfba_pkg::OP_ALLOC) begin
			run_start_q <= cand_start;
			if (take) begin
				best_len_q <= cand_len;
				best_start_q <= cand_start;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_start <= '0;
			res_len <= '0;
			res_freed <= '0;
			if (op_q == bfba_pkg::OP_ALLOC) begin
				if (found_q) begin
					res_status <= bfba_pkg::ST_ALLOCATED;
					res_start <= bfba_pkg::START_W'(8'(best_start_q));
					res_len <= bfba_pkg::LEN_W'(8'(best_len_q));
				end else begin
					res_status <= bfba_pkg::ST_NO_FIT;
				end
			end else if (count_q != '0) begin
				res_status <= bfba_pkg::ST_FREED;
				res_freed <= bfba_pkg::CNT_W'(8'(count_q));
			end else begin
				res_status <= bfba_pkg::ST_NOT_FOUND;
			end
		end
	end

endmodule

>>> rtl/bfba_ctrl.sv
module bfba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  bfba_pkg::sts_t sts,
	output bfba_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.clr_cnt = 1'b1;
				state_nx = sts.fit ? S_FILL : S_DONE;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_done) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/best_fit_block_allocator.sv
// best-fit contiguous block allocator over a map of NUM_BLOCKS owner entries
// a request passes the map walk, the fit decision and, for a successful allocation,
// a fill of request_size entries before its result is loaded for the result channel
// a new request is taken only once the last result is loaded, and a stalled result
// channel holds the block in its done state; the map walk reads one entry per cycle
// reset: arst_n clears all entry valid bits at once, every block reads free
module best_fit_block_allocator #(
	parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // owner_id [7:0], request_size [12:8], zero pad
	input  logic        s_tuser,   // operation: 0 allocate, 1 free
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // start_index [3:0], chosen_run_length [8:4],
	                               // freed_count [13:9], zero pad
	output logic [1:0]  m_tuser    // status
);

	bfba_pkg::cmd_t cmd;
	bfba_pkg::sts_t sts;

	logic [bfba_pkg::STAT_W-1:0]  res_status;
	logic [bfba_pkg::START_W-1:0] res_start;
	logic [bfba_pkg::LEN_W-1:0]   res_len;
	logic [bfba_pkg::CNT_W-1:0]   res_freed;

	// sequencer: idle, map walk, fit decision, fill, result hand-off
	bfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// block map, run tracking and result register
	bfba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_tuser),
		.in_owner   (s_tdata[7:0]),
		.in_size    (s_tdata[12:8]),
		.res_status (res_status),
		.res_start  (res_start),
		.res_len    (res_len),
		.res_freed  (res_freed)
	);

	// result packing, lowest field first
	assign m_tdata = {2'b00, res_freed, res_len, res_start};
	assign m_tuser = res_status;

endmodule

>>> rtl/bfba_checker.sv
`include "best_fit_block_allocator_macros.svh"

module bfba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic out_stall;
	logic in_xfer;
	logic not_alloc;
	logic not_freed;
	logic alloc_zero;
	logic freed_zero;

	assign out_stall = m_tvalid && !m_tready;
	assign in_xfer = s_tvalid && s_tready;
	assign not_alloc = m_tvalid && (m_tuser != bfba_pkg::ST_ALLOCATED);
	assign not_freed = m_tvalid && (m_tuser != bfba_pkg::ST_FREED);
	assign alloc_zero = (m_tdata[8:0] == 9'd0);
	assign freed_zero = (m_tdata[13:9] == 5'd0);

	`BFBA_AST_NXT(a_out_hold, clk, arst_n, out_stall, m_tvalid, "result dropped while stalled")
	`BFBA_AST_NXT(a_busy_after_req, clk, arst_n, in_xfer, !s_tready, "request taken while busy")
	`BFBA_AST_IMP(a_alloc_fields, clk, arst_n, not_alloc, alloc_zero, "stray start or length")
	`BFBA_AST_IMP(a_free_count, clk, arst_n, not_freed, freed_zero, "stray freed count")

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (.*);
